### rtl/digit_trie_prefix_checker_macros.svh
`ifndef DIGIT_TRIE_PREFIX_CHECKER_MACROS_SVH
`define DIGIT_TRIE_PREFIX_CHECKER_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define DTP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtp assertion failed");

// next-cycle implication
`define DTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtp assertion failed");

`endif

### rtl/dtp_pkg.sv
`default_nettype none

package dtp_pkg;

    localparam int NODE_COUNT_DEF = 1024;
    localparam int FANOUT         = 10;
    localparam int DIGIT_W        = 4;
    localparam int ROOT_NODE      = 1;
    localparam int FIRST_FREE     = 2;

    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic [FANOUT-1:0] kids;
        logic              end_mark;
    } node_rec_t;

    // packed so that number_done sits in bit 0
    typedef struct packed {
        logic table_full;
        logic any_conflict;
        logic number_conflict;
        logic number_done;
    } result_t;

endpackage

`default_nettype wire

### rtl/dtp_ptr_store.sv
`default_nettype none

// Child pointer table, one entry per (node, digit), addressed node*FANOUT + digit.
module dtp_ptr_store #(
    parameter int  NODE_COUNT = dtp_pkg::NODE_COUNT_DEF,
    localparam int NW         = $clog2(NODE_COUNT)
) (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic                        wr_en,
    input  wire logic [NW-1:0]               node,
    input  wire logic [dtp_pkg::DIGIT_W-1:0] digit,
    input  wire logic [NW-1:0]               wr_data,
    output logic      [NW-1:0]               rd_data
);

    localparam int DEPTH = NODE_COUNT * dtp_pkg::FANOUT;
    localparam int AW    = $clog2(DEPTH);

    logic [NW-1:0] mem [DEPTH];
    logic [AW-1:0] addr;

    assign addr = (AW'(node) * AW'(dtp_pkg::FANOUT)) + AW'(digit);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

`default_nettype wire

### rtl/dtp_node_store.sv
`default_nettype none

// Node records (child mask and end mark). The root record lives in a register so
// that a clear or reset empties it at once; every other node is in the RAM and
// gets its record written before anything can read it back.
module dtp_node_store #(
    parameter int  NODE_COUNT = dtp_pkg::NODE_COUNT_DEF,
    localparam int NW         = $clog2(NODE_COUNT)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clr,
    input  wire logic               rd_en,
    input  wire logic [NW-1:0]      rd_node,
    output dtp_pkg::node_rec_t      rd_data,
    input  wire logic               wa_en,
    input  wire logic [NW-1:0]      wa_node,
    input  wire dtp_pkg::node_rec_t wa_rec,
    input  wire logic               we_en,
    input  wire logic [NW-1:0]      we_node,
    input  wire dtp_pkg::node_rec_t we_rec,
    output dtp_pkg::node_rec_t      root_rec
);

    localparam logic [NW-1:0] ROOT = NW'(dtp_pkg::ROOT_NODE);

    dtp_pkg::node_rec_t mem [NODE_COUNT];
    dtp_pkg::node_rec_t root_reg;
    dtp_pkg::node_rec_t root_next;
    dtp_pkg::node_rec_t ram_wdata;
    logic               wa_ram;
    logic               we_ram;
    logic [NW-1:0]      ram_waddr;

    assign wa_ram = wa_en && (wa_node != ROOT);
    assign we_ram = we_en && (we_node != ROOT);

    // both requests never land in the RAM together: the accept side owns the port
    assign ram_waddr = wa_ram ? wa_node : we_node;
    assign ram_wdata = wa_ram ? wa_rec : we_rec;

    always_comb
    begin
        priority if (clr)
            root_next = '0;
        else if (wa_en && (wa_node == ROOT))
            root_next = wa_rec;
        else if (we_en && (we_node == ROOT))
            root_next = we_rec;
        else
            root_next = root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else
        begin
            root_reg <= root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wa_ram || we_ram)
        begin
            mem[ram_waddr] <= ram_wdata;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_node];
        end
    end

    assign root_rec = root_reg;

endmodule

`default_nettype wire

### rtl/digit_trie_prefix_checker.sv
`default_nettype none

// Result: registered after the input transfer, the pointer read and then the record read,
// later only while the output register is held by m_tready low.
// Issue: a new item is taken in idle or as the last one finishes, never during its pointer read.
// Reset: rst_n (async) empties the trie, parks the cursor on the root and clears all flags;
// no clearing pass is needed, a clear item takes effect at its own transfer.
module digit_trie_prefix_checker #(
    parameter int NODE_COUNT = dtp_pkg::NODE_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [3:0] digit, [7:4] zero
    input  wire logic       s_tuser,   // [0] op
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata    // [0] number_done, [1] number_conflict,
                                       // [2] any_conflict, [3] table_full, [7:4] zero
);

    localparam int            NW   = $clog2(NODE_COUNT);
    localparam logic [NW-1:0] ROOT = NW'(dtp_pkg::ROOT_NODE);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [NW-1:0]      cursor_reg;
    dtp_pkg::node_rec_t cur_rec_reg;
    logic [NW:0]        next_free_reg;
    logic               pending_reg;
    logic               sticky_reg;
    logic               ovf_reg;

    logic                        op_reg;
    logic                        last_reg;
    logic                        hit_reg;
    logic                        alloc_reg;
    logic [NW-1:0]               new_node_reg;

    logic              out_valid_reg;
    dtp_pkg::result_t  out_reg;
    dtp_pkg::result_t  out_next;

    logic                        out_ok;
    logic                        eval_go;
    logic                        s_acc;
    logic                        acc_clear;
    logic [dtp_pkg::DIGIT_W-1:0] in_digit;
    logic [dtp_pkg::FANOUT-1:0]  digit_mask;

    logic [NW-1:0]      ptr_q;
    dtp_pkg::node_rec_t node_q;
    dtp_pkg::node_rec_t root_rec;

    logic [NW-1:0]      child;
    dtp_pkg::node_rec_t child_rec;
    logic               pend;
    logic               conflict;
    logic               done;
    logic               eval_wr_en;
    dtp_pkg::node_rec_t eval_wr_rec;
    logic [NW-1:0]      nxt_cursor;
    dtp_pkg::node_rec_t nxt_rec;
    logic               pend_next;

    logic               acc_hit;
    logic               acc_free;
    logic               acc_alloc;
    logic               acc_full;
    dtp_pkg::node_rec_t acc_rec;

    assign out_ok   = !out_valid_reg || m_tready;
    assign eval_go  = (state_reg == ST_EVAL) && out_ok;
    assign s_tready = (state_reg == ST_IDLE) || eval_go;
    assign s_acc    = s_tvalid && s_tready;
    assign acc_clear = s_acc && (s_tuser == dtp_pkg::OP_CLEAR);

    assign in_digit = (s_tdata[3:0] > dtp_pkg::MAX_DIGIT) ? dtp_pkg::MAX_DIGIT : s_tdata[3:0];

    always_comb
    begin
        digit_mask           = '0;
        digit_mask[in_digit] = 1'b1;
    end

    // Finish the item in flight. The next item may be taken in this same cycle,
    // so everything it needs (cursor, cached record) is forwarded from here.
    always_comb
    begin
        child       = cursor_reg;
        child_rec   = cur_rec_reg;
        pend        = pending_reg;
        conflict    = 1'b0;
        done        = 1'b0;
        eval_wr_en  = 1'b0;
        eval_wr_rec = cur_rec_reg;
        nxt_cursor  = cursor_reg;
        nxt_rec     = cur_rec_reg;
        pend_next   = pending_reg;
        if (eval_go && (op_reg == dtp_pkg::OP_INSERT))
        begin
            priority if (hit_reg)
            begin
                child     = ptr_q;
                child_rec = node_q;
            end
            else if (alloc_reg)
            begin
                child     = new_node_reg;
                child_rec = '0;
            end
            else
            begin
                // table full: walk stays where it is
                child     = cursor_reg;
                child_rec = cur_rec_reg;
            end
            pend = pending_reg || child_rec.end_mark;
            if (last_reg)
            begin
                done                 = 1'b1;
                conflict             = pend || (|child_rec.kids);
                eval_wr_rec.kids     = child_rec.kids;
                eval_wr_rec.end_mark = 1'b1;
                eval_wr_en           = 1'b1;
                nxt_cursor           = ROOT;
                nxt_rec              = (child == ROOT) ? eval_wr_rec : root_rec;
                pend_next            = 1'b0;
            end
            else
            begin
                nxt_cursor = child;
                nxt_rec    = child_rec;
                pend_next  = pend;
            end
        end
    end

    assign acc_hit   = |(nxt_rec.kids & digit_mask);
    assign acc_free  = next_free_reg < (NW+1)'(NODE_COUNT);
    assign acc_alloc = s_acc && !acc_clear && !acc_hit && acc_free;
    assign acc_full  = s_acc && !acc_clear && !acc_hit && !acc_free;

    always_comb
    begin
        acc_rec      = nxt_rec;
        acc_rec.kids = nxt_rec.kids | digit_mask;
    end

    dtp_ptr_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_ptr (
        .clk     (clk),
        .rd_en   (s_acc),
        .wr_en   (acc_alloc),
        .node    (nxt_cursor),
        .digit   (in_digit),
        .wr_data (next_free_reg[NW-1:0]),
        .rd_data (ptr_q)
    );

    dtp_node_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_node (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (acc_clear),
        .rd_en    ((state_reg == ST_WALK) && hit_reg && (op_reg == dtp_pkg::OP_INSERT)),
        .rd_node  (ptr_q),
        .rd_data  (node_q),
        .wa_en    (acc_alloc),
        .wa_node  (nxt_cursor),
        .wa_rec   (acc_rec),
        .we_en    (eval_wr_en),
        .we_node  (child),
        .we_rec   (eval_wr_rec),
        .root_rec (root_rec)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = s_acc ? ST_WALK : ST_IDLE;
            ST_WALK: state_next = ST_EVAL;
            ST_EVAL:
            begin
                priority if (s_acc)
                    state_next = ST_WALK;
                else if (out_ok)
                    state_next = ST_IDLE;
                else
                    state_next = ST_EVAL;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_next.number_done     = done;
        out_next.number_conflict = conflict;
        out_next.any_conflict    = sticky_reg || conflict;
        out_next.table_full      = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= ROOT;
            cur_rec_reg   <= '0;
            next_free_reg <= (NW+1)'(dtp_pkg::FIRST_FREE);
            pending_reg   <= 1'b0;
            sticky_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc_clear)
            begin
                cursor_reg    <= ROOT;
                cur_rec_reg   <= '0;
                next_free_reg <= (NW+1)'(dtp_pkg::FIRST_FREE);
                pending_reg   <= 1'b0;
                sticky_reg    <= 1'b0;
                ovf_reg       <= 1'b0;
            end
            else
            begin
                cursor_reg  <= nxt_cursor;
                cur_rec_reg <= acc_alloc ? acc_rec : nxt_rec;
                pending_reg <= pend_next;
                if (acc_alloc)
                begin
                    next_free_reg <= next_free_reg + 1'b1;
                end
                if (conflict)
                begin
                    sticky_reg <= 1'b1;
                end
                if (acc_full)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (eval_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            op_reg       <= s_tuser;
            last_reg     <= s_tlast;
            hit_reg      <= acc_hit;
            alloc_reg    <= acc_alloc;
            new_node_reg <= next_free_reg[NW-1:0];
        end
        if (eval_go)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg};

endmodule

`default_nettype wire

### rtl/dtp_port_checker.sv
`default_nettype none

`include "digit_trie_prefix_checker_macros.svh"

module dtp_port_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // an input transfer is always followed by the record walk
    `DTP_ASSERT_NEXT(a_two_cycle_issue, s_tvalid && s_tready, !s_tready)
    `DTP_ASSERT_IMPL(a_conflict_needs_done, m_tvalid && m_tdata[1], m_tdata[0])
    `DTP_ASSERT_IMPL(a_sticky_covers_conflict, m_tvalid && m_tdata[1], m_tdata[2])
    `DTP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind digit_trie_prefix_checker dtp_port_checker u_port_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int NODES      = dtp_pkg::NODE_COUNT_DEF;
    localparam int FAN        = dtp_pkg::FANOUT;
    localparam int DW         = dtp_pkg::DIGIT_W;
    localparam int IDLE_LIMIT = 1000;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    digit_trie_prefix_checker #(
        .NODE_COUNT(NODES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Mirror of the trie plus the queue of results still owed by the block
    class prefix_tracker;
        int unsigned        kid_ptr [NODES][FAN];
        logic [FAN-1:0]     kid_mask [NODES];
        bit                 ends_here [NODES];
        int unsigned        cursor;
        int unsigned        next_free;
        bit                 pending;
        bit                 sticky;
        bit                 overflow;
        dtp_pkg::result_t   awaited_results[$];
        int                 errors;

        function new();
            errors = 0;
            empty_trie();
        endfunction

        function void empty_trie();
            for (int i = 0; i < NODES; i++)
            begin
                kid_mask[i]  = '0;
                ends_here[i] = 1'b0;
            end
            cursor    = dtp_pkg::ROOT_NODE;
            next_free = dtp_pkg::FIRST_FREE;
            pending   = 1'b0;
            sticky    = 1'b0;
            overflow  = 1'b0;
        endfunction

        function void note_digit(logic op, logic [DW-1:0] digit, logic last);
            dtp_pkg::result_t r;
            int unsigned      cur;
            int unsigned      d;
            int unsigned      n;
            r   = '0;
            cur = cursor % NODES;
            if (op == dtp_pkg::OP_CLEAR)
                empty_trie();
            else
            begin
                d = 32'((digit > dtp_pkg::MAX_DIGIT) ? dtp_pkg::MAX_DIGIT : digit);
                if (kid_mask[cur][d])
                    cur = kid_ptr[cur][d] % NODES;
                else if (next_free < NODES)
                begin
                    n = next_free;
                    next_free++;
                    kid_mask[n]     = '0;
                    ends_here[n]    = 1'b0;
                    kid_ptr[cur][d] = n;
                    kid_mask[cur][d] = 1'b1;
                    cur = n;
                end
                else
                    overflow = 1'b1;
                if (ends_here[cur])
                    pending = 1'b1;
                if (last)
                begin
                    r.number_done     = 1'b1;
                    r.number_conflict = pending || (kid_mask[cur] != '0);
                    ends_here[cur]    = 1'b1;
                    if (r.number_conflict)
                        sticky = 1'b1;
                    pending = 1'b0;
                    cur     = dtp_pkg::ROOT_NODE;
                end
                cursor = cur;
            end
            r.any_conflict = sticky;
            r.table_full   = overflow;
            awaited_results = {awaited_results, r};
        endfunction

        function void check_result(logic [7:0] data);
            dtp_pkg::result_t want;
            dtp_pkg::result_t got;
            got = data[3:0];
            if (awaited_results.size() == 0)
            begin
                $error("result transfer with nothing outstanding: %h", data);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.number_done !== want.number_done)
            begin
                $error("number_done: expected %0b, got %0b", want.number_done, got.number_done);
                errors++;
            end
            if (got.number_conflict !== want.number_conflict)
            begin
                $error("number_conflict: expected %0b, got %0b",
                       want.number_conflict, got.number_conflict);
                errors++;
            end
            if (got.any_conflict !== want.any_conflict)
            begin
                $error("any_conflict: expected %0b, got %0b",
                       want.any_conflict, got.any_conflict);
                errors++;
            end
            if (got.table_full !== want.table_full)
            begin
                $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
                errors++;
            end
            if (data[7:4] !== 4'h0)
            begin
                $error("pad: expected 0, got %h", data[7:4]);
                errors++;
            end
        endfunction
    endclass

    prefix_tracker tracker = new();

    int unsigned items_sent  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // checks first, so an expectation noted at this edge is never matched here
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if (s_tvalid && s_tready)
                tracker.note_digit(s_tuser, s_tdata[DW-1:0], s_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver: runs of always-ready, random, periodic and long-stall patterns
    initial
    begin
        int mode;
        int len;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 40);
            for (int i = 0; i < len; i++)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ((i % 4) != 3);
                    default: m_tready <= (i >= len / 2);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_item(logic op, logic [DW-1:0] digit, logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, digit};
        s_tuser  <= op;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_number(int len, int top);
        for (int i = 0; i < len; i++)
            send_item(dtp_pkg::OP_INSERT, DW'($urandom_range(0, top)), i == len - 1);
    endtask

    // hold off until every outstanding result has arrived
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic mixed_traffic(int count);
        int unsigned stop_at;
        int kind;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 78)
                // small alphabets make shared prefixes and duplicates common
                send_number($urandom_range(1, 5),
                            ($urandom_range(0, 4) == 0) ? 15 : $urandom_range(1, 3));
            else if (kind < 88)
            begin
                send_number($urandom_range(1, 4), 3);
                send_item(dtp_pkg::OP_INSERT, DW'($urandom_range(0, 15)), 1'b0);
                send_item(dtp_pkg::OP_CLEAR, DW'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
            end
            else if (kind < 97)
                send_item(dtp_pkg::OP_INSERT, DW'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
            else
                send_item(dtp_pkg::OP_CLEAR, DW'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: prefix both ways, duplicate, clamped digits, clears
        send_item(dtp_pkg::OP_INSERT, 4'd5, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd5, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd3, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd9, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd9, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd9, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd0, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd0, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd15, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd10, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd12, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd1, 1'b0);
        send_item(dtp_pkg::OP_CLEAR, 4'd15, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd1, 1'b1);
        send_item(dtp_pkg::OP_CLEAR, 4'd0, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd7, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd6, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd4, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd7, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd6, 1'b1);
        send_item(dtp_pkg::OP_INSERT, 4'd2, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd11, 1'b0);
        send_item(dtp_pkg::OP_INSERT, 4'd8, 1'b1);
        wait_drain();

        mixed_traffic(50);
        wait_drain();

        // fill the node table: long, mostly disjoint numbers until allocation fails
        send_item(dtp_pkg::OP_CLEAR, DW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        while (!tracker.overflow)
            send_number($urandom_range(8, 14),
                        ($urandom_range(0, 9) == 0) ? 15 : 9);
        for (int i = 0; i < 8; i++)
            send_number($urandom_range(1, 6), 15);
        wait_drain();

        send_item(dtp_pkg::OP_CLEAR, DW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        mixed_traffic(25);
        wait_drain();

        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
